@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the decoder RTL files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define USD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define USD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/usd_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every decoder module.
package usd_pkg;

    // Byte classes of the extended UTF-8 encoding
    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] LEAD2_MIN = 8'hC0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;
    localparam logic [7:0] LEAD4_MIN = 8'hF0;
    localparam logic [7:0] LEAD5_MIN = 8'hF8;
    localparam logic [7:0] LEAD6_MIN = 8'hFC;
    localparam logic [7:0] BAD_LEAD_MIN = 8'hFE;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    // Held continuation bytes in a flush: at most four
    localparam int MAX_HELD  = 4;
    localparam int GROUP_W   = 6;
    localparam int HELD_W    = MAX_HELD * GROUP_W;
    localparam int CP_W      = 31;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One command: optional raw flush of an open sequence, then an optional tail word
    typedef struct packed {
        logic                flush;
        logic [7:0]          lead;
        logic [2:0]          held;
        logic [HELD_W-1:0]   held_bits;
        logic                tail;
        logic [CP_W-1:0]     tail_cp;
        logic                tail_bad;
    } cmd_t;

endpackage

@@ hw/rtl/utf8_stream_decoder_unit.sv @@
// Top level of the extended UTF-8 stream decoder.
// Depends on usd_pkg, usd_front, usd_cmd_queue and usd_back.
//
//   channel  | handshake        | words
//   ---------+------------------+-----------------------------------------
//   input    | push / full      | data_byte, end_of_stream
//   result   | pop / empty      | code_point, malformed, last_of_run
//
// One byte is accepted per cycle while the command queue has room; each byte
// yields zero to six result words, delivered one per cycle from the output
// register while results are popped. Results pass the queue, then that register.
// Rate is set by the back end: a byte that breaks a sequence holds it for
// up to six result words while the four-entry command queue absorbs new bytes.
// Reset (rst_n low, asynchronous) closes any open sequence and empties both sides.
module utf8_stream_decoder_unit
    import usd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      data_byte,
    input  logic            end_of_stream,
    input  logic            push,
    output logic            full,
    output logic [CP_W-1:0] code_point,
    output logic            malformed,
    output logic            last_of_run,
    output logic            empty,
    input  logic            pop
);

    logic accept;
    logic cmd_valid;
    cmd_t cmd;
    cmd_t head_cmd;
    logic q_empty;
    logic q_pop;

    assign accept = push && !full;

    usd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd)
    );

    usd_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_valid),
        .push_cmd (cmd),
        .full     (full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    usd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .code_point  (code_point),
        .malformed   (malformed),
        .last_of_run (last_of_run),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

@@ hw/rtl/usd_front.sv @@
// Front end: accepts bytes, tracks the open sequence, builds at most one command per byte.
// Depends on usd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module usd_front
    import usd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output logic       cmd_valid,
    output cmd_t       cmd
);

    logic [7:0]  lead_reg, lead_next;
    logic [2:0]  need_reg, need_next;
    logic [2:0]  rcv_reg,  rcv_next;
    logic [29:0] pay_reg,  pay_next;

    logic        is_cont;
    logic        fresh_emit;
    logic [2:0]  fresh_need;
    logic [29:0] pay_acc;
    logic [2:0]  rcv_acc;
    logic [CP_W-1:0] lead_part;

    // Classify the byte as a fresh start
    always_comb
    begin
        is_cont    = (data_byte[7:6] == CONT_TAG);
        fresh_emit = (data_byte < LEAD2_MIN) || (data_byte >= BAD_LEAD_MIN) || end_of_stream;
        if (data_byte < LEAD3_MIN)
            fresh_need = 3'd1;
        else if (data_byte < LEAD4_MIN)
            fresh_need = 3'd2;
        else if (data_byte < LEAD5_MIN)
            fresh_need = 3'd3;
        else if (data_byte < LEAD6_MIN)
            fresh_need = 3'd4;
        else
            fresh_need = 3'd5;
    end

    // Append the continuation group and place the lead payload bits
    always_comb
    begin
        pay_acc = {pay_reg[23:0], data_byte[5:0]};
        rcv_acc = rcv_reg + 3'd1;
        case (need_reg)
            3'd1:    lead_part = CP_W'(lead_reg[4:0]) << 6;
            3'd2:    lead_part = CP_W'(lead_reg[3:0]) << 12;
            3'd3:    lead_part = CP_W'(lead_reg[2:0]) << 18;
            3'd4:    lead_part = CP_W'(lead_reg[1:0]) << 24;
            3'd5:    lead_part = CP_W'(lead_reg[0]) << 30;
            default: lead_part = '0;
        endcase
    end

    // Decide the command and the next sequence state
    always_comb
    begin
        lead_next = lead_reg;
        need_next = need_reg;
        rcv_next  = rcv_reg;
        pay_next  = pay_reg;
        cmd       = '0;
        if (accept)
        begin
            if (need_reg == 3'd0 || !is_cont)
            begin
                // flush an open sequence that the byte breaks
                if (need_reg != 3'd0)
                begin
                    cmd.flush     = 1'b1;
                    cmd.lead      = lead_reg;
                    cmd.held      = rcv_reg;
                    cmd.held_bits = pay_reg[HELD_W-1:0];
                end
                lead_next = '0;
                need_next = '0;
                rcv_next  = '0;
                pay_next  = '0;
                if (fresh_emit)
                begin
                    cmd.tail     = 1'b1;
                    cmd.tail_cp  = CP_W'(data_byte);
                    cmd.tail_bad = data_byte[7];
                end
                else
                begin
                    lead_next = data_byte;
                    need_next = fresh_need;
                end
            end
            else if (rcv_acc >= need_reg)
            begin
                // complete the sequence
                cmd.tail    = 1'b1;
                cmd.tail_cp = lead_part | CP_W'(pay_acc);
                lead_next   = '0;
                need_next   = '0;
                rcv_next    = '0;
                pay_next    = '0;
            end
            else if (end_of_stream)
            begin
                // stream ends inside the sequence: drop it out raw
                cmd.flush     = 1'b1;
                cmd.lead      = lead_reg;
                cmd.held      = rcv_acc;
                cmd.held_bits = pay_acc[HELD_W-1:0];
                lead_next     = '0;
                need_next     = '0;
                rcv_next      = '0;
                pay_next      = '0;
            end
            else
            begin
                // hold the continuation byte
                rcv_next = rcv_acc;
                pay_next = pay_acc;
            end
        end
        cmd_valid = accept && (cmd.flush || cmd.tail);
    end

    // Hold sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= '0;
            need_reg <= '0;
            rcv_reg  <= '0;
            pay_reg  <= '0;
        end
        else
        begin
            lead_reg <= lead_next;
            need_reg <= need_next;
            rcv_reg  <= rcv_next;
            pay_reg  <= pay_next;
        end
    end

    `USD_ASSERT_NOW(a_closed_clean, clk, rst_n, need_reg == 3'd0,
        rcv_reg == 3'd0 && lead_reg == 8'h00 && pay_reg == 30'd0, "closed state not clear")
    `USD_ASSERT_NOW(a_open_bounds, clk, rst_n, need_reg != 3'd0,
        rcv_reg < need_reg && need_reg <= 3'd5, "open sequence count out of range")
    `USD_ASSERT_NOW(a_open_lead, clk, rst_n, need_reg != 3'd0,
        lead_reg >= LEAD2_MIN && lead_reg < BAD_LEAD_MIN, "open sequence without a lead")

endmodule

@@ hw/rtl/usd_cmd_queue.sv @@
// Short command queue between the decoder front and back.
// Depends on usd_pkg.
module usd_cmd_queue
    import usd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty
);

    cmd_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg,  count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    // Advance pointers; depth is a power of two so they wrap naturally
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the command word
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ hw/rtl/usd_back.sv @@
// Back end: expands each command into result words through an output register.
// Depends on usd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module usd_back
    import usd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cmd_t            head_cmd,
    input  logic            q_empty,
    output logic            q_pop,
    output logic [CP_W-1:0] code_point,
    output logic            malformed,
    output logic            last_of_run,
    output logic            empty,
    input  logic            pop
);

    logic [2:0]      idx_reg, idx_next;
    logic            valid_reg, valid_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic            bad_reg, bad_next;
    logic            last_reg, last_next;

    logic            advance;
    logic            produce;
    logic [2:0]      word_cnt;
    logic [2:0]      sel_full;
    logic [1:0]      sel;
    logic [5:0]      group;
    logic            is_last;

    assign advance = !valid_reg || pop;
    assign produce = advance && !q_empty;
    assign q_pop   = produce && is_last;

    // Pick the word at the current step of the head command
    always_comb
    begin
        word_cnt = (head_cmd.flush ? 3'd1 + head_cmd.held : 3'd0) + 3'(head_cmd.tail);
        is_last  = (idx_reg == word_cnt - 3'd1);
        sel_full = head_cmd.held - idx_reg;
        sel      = sel_full[1:0];
        case (sel)
            2'd0:    group = head_cmd.held_bits[5:0];
            2'd1:    group = head_cmd.held_bits[11:6];
            2'd2:    group = head_cmd.held_bits[17:12];
            2'd3:    group = head_cmd.held_bits[23:18];
            default: group = '0;
        endcase
        if (head_cmd.flush && idx_reg == 3'd0)
        begin
            cp_next  = CP_W'(head_cmd.lead);
            bad_next = 1'b1;
        end
        else if (head_cmd.flush && idx_reg <= head_cmd.held)
        begin
            cp_next  = CP_W'({2'b10, group});
            bad_next = 1'b1;
        end
        else
        begin
            cp_next  = head_cmd.tail_cp;
            bad_next = head_cmd.tail_bad;
        end
        last_next = is_last;
    end

    // Step through the command; restart at its last word
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance)
            valid_next = !q_empty;
        if (produce)
            idx_next = is_last ? 3'd0 : idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            cp_reg   <= cp_next;
            bad_reg  <= bad_next;
            last_reg <= last_next;
        end
    end

    assign code_point  = cp_reg;
    assign malformed   = bad_reg;
    assign last_of_run = last_reg;
    assign empty       = !valid_reg;

    `USD_ASSERT_NOW(a_idle_step, clk, rst_n, q_empty, idx_reg == 3'd0,
        "step counter not at rest with no command")
    `USD_ASSERT_NOW(a_step_bound, clk, rst_n, !q_empty, idx_reg < word_cnt,
        "step counter past end of command")
    `USD_ASSERT_NEXT(a_pop_on_last, clk, rst_n, produce && is_last,
        valid_reg && last_of_run, "command finished without a last word")

endmodule
